// File: hw/rtl/sbspc_pkg.sv
// ----------------------------------------------------------------------------
// sbspc_pkg: shared types and constants of the servo status packet checker
// Item codes, status codes, field widths and the judge input bundle.
// ----------------------------------------------------------------------------
package sbspc_pkg;

  localparam int BYTE_W    = 8;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int TMO_W     = 16;
  localparam int IDLE_W    = TMO_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = TMO_W;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;
  // Packets of this many bytes or fewer are not checked.
  localparam logic [BYTE_W-1:0] MIN_CHECKED = 8'd3;
  // Bytes of the packet that the length field does not count.
  localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd4;

  localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 16'd30000;
  localparam logic [BYTE_W-1:0] BROADCAST_RST = 8'd254;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_HEADER    = 3'd1,
    ST_ID        = 3'd2,
    ST_LENGTH    = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_UNCHECKED = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_LIMIT = 1'd0,
    CFG_BROADCAST_ID  = 1'd1
  } cfg_idx_t;

  // Packet state as seen by the end-of-packet judge.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_count;
    logic [BYTE_W-1:0] target_id;
    logic              header_bad;
    logic              id_bad;
    logic [BYTE_W-1:0] length_field;
    logic [BYTE_W-1:0] running_sum;
  } judge_in_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] packet_length;
  } judge_out_t;

endpackage

// File: hw/rtl/sbspc_ifs.sv
// ----------------------------------------------------------------------------
// sbspc_ifs: item channels of the servo status packet checker
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sbspc_in_if;
  logic                          valid;
  logic                          ready;
  logic [sbspc_pkg::FUNC_W-1:0]  func;
  logic [sbspc_pkg::BYTE_W-1:0]  rx_byte;
  logic [sbspc_pkg::BYTE_W-1:0]  expected_id;
  logic [sbspc_pkg::BYTE_W-1:0]  expected_len;

  modport source (output valid, func, rx_byte, expected_id, expected_len,
                  input ready);
  modport sink   (input valid, func, rx_byte, expected_id, expected_len,
                  output ready);
endinterface

interface sbspc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           byte_valid;
  logic [sbspc_pkg::BYTE_W-1:0]   byte_out;
  logic [sbspc_pkg::BYTE_W-1:0]   byte_index;
  logic                           done_res;
  logic                           timed_out;
  logic [sbspc_pkg::STATUS_W-1:0] status;
  logic [sbspc_pkg::BYTE_W-1:0]   packet_length;

  modport source (output valid, byte_valid, byte_out, byte_index, done_res,
                  timed_out, status, packet_length, input ready);
  modport sink   (input valid, byte_valid, byte_out, byte_index, done_res,
                  timed_out, status, packet_length, output ready);
endinterface

// File: hw/rtl/sbspc_judge.sv
// ----------------------------------------------------------------------------
// sbspc_judge: end-of-packet checks
// Checks header, ID, length field and checksum in priority order; skips them for the broadcast ID and short packets.
// ----------------------------------------------------------------------------
module sbspc_judge (
  input  sbspc_pkg::judge_in_t         st_i,
  input  logic [sbspc_pkg::BYTE_W-1:0] broadcast_id_i,
  output sbspc_pkg::judge_out_t        res_o
);

  logic [sbspc_pkg::BYTE_W-1:0] len_expect;

  assign len_expect = st_i.byte_count - sbspc_pkg::LEN_OVERHEAD;

  always_comb begin
    res_o.status        = sbspc_pkg::ST_OK;
    res_o.packet_length = st_i.byte_count;
    if (st_i.target_id == broadcast_id_i || st_i.byte_count <= sbspc_pkg::MIN_CHECKED) begin
      res_o.status = sbspc_pkg::ST_UNCHECKED;
    end else begin
      if (st_i.header_bad) begin
        res_o.status = sbspc_pkg::ST_HEADER;
      end else if (st_i.id_bad) begin
        res_o.status = sbspc_pkg::ST_ID;
      end else if (st_i.length_field != len_expect) begin
        res_o.status = sbspc_pkg::ST_LENGTH;
      end else if (st_i.running_sum != sbspc_pkg::SUM_GOOD) begin
        res_o.status = sbspc_pkg::ST_CHECKSUM;
      end
      // Drop the length on any failed check.
      if (res_o.status != sbspc_pkg::ST_OK) begin
        res_o.packet_length = '0;
      end
    end
  end

endmodule

// File: hw/rtl/servo_bus_status_packet_checker.sv
// ----------------------------------------------------------------------------
// servo_bus_status_packet_checker: status packet checker for a serial servo bus
// Echoes reply bytes with their position and judges the packet at its end.
// ----------------------------------------------------------------------------
// A start item arms the checker with the addressed ID and the expected reply
// length; each received-byte item of an open packet returns one result echoing
// the byte and its position, and the packet ends after the expected count of
// bytes or when more than timeout_limit idle-tick items arrive in a row. The
// final result carries done_res, timed_out, a status code and the packet
// length (zero after a failed check; no checks for the broadcast ID or for
// packets of three bytes or fewer). State update and the end-of-packet judge
// sit between the packet state registers and a single result register, so an
// item can be accepted on every clock while the result register is empty or
// being taken in the same cycle. Results appear in the cycle after their
// item. Configuration must be written through cfg_we / cfg_index / cfg_data
// only while no packet is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module servo_bus_status_packet_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  sbspc_in_if.sink                           in_ch,
  sbspc_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [sbspc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbspc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  logic [sbspc_pkg::TMO_W-1:0]  timeout_limit_r;
  logic [sbspc_pkg::BYTE_W-1:0] broadcast_id_r;

  // Packet state
  logic                          active_r, active_nxt;
  logic [sbspc_pkg::BYTE_W-1:0]  target_len_r, target_len_nxt;
  logic [sbspc_pkg::IDLE_W-1:0]  idle_count_r, idle_count_nxt;
  sbspc_pkg::judge_in_t          pkt_r, pkt_nxt;

  // Result of the current item
  logic                          res_valid;
  logic                          res_byte_valid;
  logic [sbspc_pkg::BYTE_W-1:0]  res_byte_out;
  logic [sbspc_pkg::BYTE_W-1:0]  res_byte_index;
  logic                          res_done;
  logic                          res_timed_out;
  sbspc_pkg::judge_out_t         judge_res;

  // Result register
  logic                           out_valid_r;
  logic                           out_byte_valid_r;
  logic [sbspc_pkg::BYTE_W-1:0]   out_byte_out_r;
  logic [sbspc_pkg::BYTE_W-1:0]   out_byte_index_r;
  logic                           out_done_r;
  logic                           out_timed_out_r;
  logic [sbspc_pkg::STATUS_W-1:0] out_status_r;
  logic [sbspc_pkg::BYTE_W-1:0]   out_length_r;

  logic in_fire;
  logic out_fire;

  // Accept while the result register is free or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= sbspc_pkg::TIMEOUT_RST;
      broadcast_id_r  <= sbspc_pkg::BROADCAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbspc_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_data;
        sbspc_pkg::CFG_BROADCAST_ID:  broadcast_id_r  <= cfg_data[sbspc_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Item decode and packet state update
  always_comb begin
    active_nxt     = active_r;
    target_len_nxt = target_len_r;
    idle_count_nxt = idle_count_r;
    pkt_nxt        = pkt_r;
    res_valid      = 1'b0;
    res_byte_valid = 1'b0;
    res_byte_out   = '0;
    res_byte_index = '0;
    res_done       = 1'b0;
    res_timed_out  = 1'b0;

    if (in_fire) begin
      unique case (in_ch.func)
        sbspc_pkg::FUNC_START: begin
          // Drop any running packet and arm a new one.
          pkt_nxt.target_id    = in_ch.expected_id;
          pkt_nxt.byte_count   = '0;
          pkt_nxt.header_bad   = 1'b0;
          pkt_nxt.id_bad       = 1'b0;
          pkt_nxt.length_field = '0;
          pkt_nxt.running_sum  = '0;
          target_len_nxt       = in_ch.expected_len;
          idle_count_nxt       = '0;
          if (in_ch.expected_len == '0) begin
            // Nothing expected: end at once.
            active_nxt = 1'b0;
            res_valid  = 1'b1;
            res_done   = 1'b1;
          end else begin
            active_nxt = 1'b1;
          end
        end
        sbspc_pkg::FUNC_BYTE: begin
          if (active_r) begin
            if (pkt_r.byte_count <= 8'd1 && in_ch.rx_byte != sbspc_pkg::HDR_BYTE) begin
              pkt_nxt.header_bad = 1'b1;
            end
            if (pkt_r.byte_count == 8'd2 && in_ch.rx_byte != pkt_r.target_id) begin
              pkt_nxt.id_bad = 1'b1;
            end
            if (pkt_r.byte_count == 8'd3) begin
              pkt_nxt.length_field = in_ch.rx_byte;
            end
            // Checksum covers the ID byte onward.
            if (pkt_r.byte_count >= 8'd2) begin
              pkt_nxt.running_sum = pkt_r.running_sum + in_ch.rx_byte;
            end
            pkt_nxt.byte_count = pkt_r.byte_count + 8'd1;
            idle_count_nxt     = '0;
            res_valid          = 1'b1;
            res_byte_valid     = 1'b1;
            res_byte_out       = in_ch.rx_byte;
            res_byte_index     = pkt_r.byte_count;
            if (pkt_nxt.byte_count == target_len_r) begin
              active_nxt = 1'b0;
              res_done   = 1'b1;
            end
          end
        end
        sbspc_pkg::FUNC_TICK: begin
          if (active_r) begin
            idle_count_nxt = idle_count_r + 1'b1;
            if (idle_count_nxt > {1'b0, timeout_limit_r}) begin
              active_nxt    = 1'b0;
              res_valid     = 1'b1;
              res_done      = 1'b1;
              res_timed_out = 1'b1;
            end
          end
        end
        default: ;  // unused code: ignore
      endcase
    end
  end

  // Judge the packet as it stands after this item.
  sbspc_judge u_judge (
    .st_i           (pkt_nxt),
    .broadcast_id_i (broadcast_id_r),
    .res_o          (judge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      target_len_r <= '0;
      idle_count_r <= '0;
      pkt_r        <= '0;
    end else begin
      active_r     <= active_nxt;
      target_len_r <= target_len_nxt;
      idle_count_r <= idle_count_nxt;
      pkt_r        <= pkt_nxt;
    end
  end

  // Result register: load on a result, clear once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_byte_valid_r <= res_byte_valid;
      out_byte_out_r   <= res_byte_out;
      out_byte_index_r <= res_byte_index;
      out_done_r       <= res_done;
      out_timed_out_r  <= res_timed_out;
      out_status_r     <= res_done ? judge_res.status : sbspc_pkg::ST_OK;
      out_length_r     <= res_done ? judge_res.packet_length : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.byte_valid    = out_byte_valid_r;
  assign out_ch.byte_out      = out_byte_out_r;
  assign out_ch.byte_index    = out_byte_index_r;
  assign out_ch.done_res      = out_done_r;
  assign out_ch.timed_out     = out_timed_out_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.packet_length = out_length_r;

  // An ending result leaves the checker idle.
  a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && res_done) |=> !active_r)
    else $error("packet ended but checker still active");

  // A failed check never reports a length.
  a_fail_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r && out_status_r != sbspc_pkg::ST_OK &&
     out_status_r != sbspc_pkg::ST_UNCHECKED) |-> (out_length_r == '0))
    else $error("failed packet reports nonzero length");

  // A timeout result never echoes a byte.
  a_timeout_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_timed_out_r) |-> (out_done_r && !out_byte_valid_r))
    else $error("timeout result carries a byte");

  // Idle count stays within the limit while a packet is open.
  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idle_count_r <= {1'b0, timeout_limit_r}))
    else $error("idle count beyond timeout limit while active");

endmodule

// File: tb/tb_servo_bus_status_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_bus_status_packet_checker: self-checking bench of the packet checker
// Drives start, byte and tick items over valid/ready, predicts every echo and
// end-of-packet verdict in a scoreboard, and compares each result in order.
// ----------------------------------------------------------------------------
module tb_servo_bus_status_packet_checker;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int SETTLE       = 4;     // settle wait after draining, with margin
  localparam int LONG_IDLE    = 100;   // idle ticks under the largest limit

  typedef logic [sbspc_pkg::BYTE_W-1:0] byte_t;
  typedef logic [sbspc_pkg::FUNC_W-1:0] func_code_t;
  typedef logic [sbspc_pkg::TMO_W-1:0]  limit_t;

  typedef struct packed {
    logic [sbspc_pkg::FUNC_W-1:0] func;
    logic [sbspc_pkg::BYTE_W-1:0] rx_byte;
    logic [sbspc_pkg::BYTE_W-1:0] expected_id;
    logic [sbspc_pkg::BYTE_W-1:0] expected_len;
  } servo_item_t;

  typedef struct packed {
    logic                         byte_valid;
    logic [sbspc_pkg::BYTE_W-1:0] byte_out;
    logic [sbspc_pkg::BYTE_W-1:0] byte_index;
    logic                         done_res;
    logic                         timed_out;
    sbspc_pkg::status_t           status;
    logic [sbspc_pkg::BYTE_W-1:0] packet_length;
  } reply_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the packet state and registers, plus the queue of
  // replies the block still owes.
  // --------------------------------------------------------------------------
  class packet_scoreboard;
    reply_t                       owed_replies[$];
    int                           mismatches;
    int                           checked;
    int                           timeouts;
    int                           status_tally[6];
    bit                           armed;
    logic [sbspc_pkg::BYTE_W-1:0] rx_count;
    logic [sbspc_pkg::BYTE_W-1:0] addr_id;
    logic [sbspc_pkg::BYTE_W-1:0] want_len;
    logic [sbspc_pkg::BYTE_W-1:0] len_byte;
    logic [sbspc_pkg::BYTE_W-1:0] csum;
    bit                           hdr_err;
    bit                           id_err;
    logic [sbspc_pkg::IDLE_W-1:0] idle_ticks;
    logic [sbspc_pkg::TMO_W-1:0]  tmo_limit;
    logic [sbspc_pkg::BYTE_W-1:0] bcast_id;

    function new();
      tmo_limit  = sbspc_pkg::TIMEOUT_RST;
      bcast_id   = sbspc_pkg::BROADCAST_RST;
      armed      = 0;
      rx_count   = '0;
      addr_id    = '0;
      want_len   = '0;
      len_byte   = '0;
      csum       = '0;
      hdr_err    = 0;
      id_err     = 0;
      idle_ticks = '0;
    endfunction

    function void set_reg(sbspc_pkg::cfg_idx_t idx,
                          logic [sbspc_pkg::CFG_DATA_W-1:0] data);
      if (idx == sbspc_pkg::CFG_TIMEOUT_LIMIT) tmo_limit = data;
      else bcast_id = data[sbspc_pkg::BYTE_W-1:0];
    endfunction

    // Final reply of a packet: judge the collected state.
    function reply_t end_packet(bit echo, byte_t b, byte_t pos, bit tmo);
      reply_t r;
      r = '0;
      r.byte_valid = echo;
      r.byte_out   = b;
      r.byte_index = pos;
      r.done_res   = 1'b1;
      r.timed_out  = tmo;
      if (addr_id == bcast_id || rx_count <= sbspc_pkg::MIN_CHECKED) begin
        r.status        = sbspc_pkg::ST_UNCHECKED;
        r.packet_length = rx_count;
      end else begin
        if (hdr_err) r.status = sbspc_pkg::ST_HEADER;
        else if (id_err) r.status = sbspc_pkg::ST_ID;
        else if (len_byte != rx_count - sbspc_pkg::LEN_OVERHEAD) r.status = sbspc_pkg::ST_LENGTH;
        else if (csum != sbspc_pkg::SUM_GOOD) r.status = sbspc_pkg::ST_CHECKSUM;
        else r.status = sbspc_pkg::ST_OK;
        r.packet_length = (r.status == sbspc_pkg::ST_OK) ? rx_count : '0;
      end
      return r;
    endfunction

    // Note an accepted item; returns 0 when the block ignores it.
    function bit note_item(servo_item_t it);
      reply_t r;
      byte_t  pos;
      case (it.func)
        sbspc_pkg::FUNC_START: begin
          addr_id    = it.expected_id;
          want_len   = it.expected_len;
          rx_count   = '0;
          hdr_err    = 0;
          id_err     = 0;
          len_byte   = '0;
          csum       = '0;
          idle_ticks = '0;
          if (want_len == 0) begin
            armed = 0;
            owed_replies.push_back(end_packet(0, '0, '0, 0));
          end else begin
            armed = 1;
          end
          return 1;
        end
        sbspc_pkg::FUNC_BYTE: begin
          if (!armed) return 0;
          pos = rx_count;
          if (pos <= 1 && it.rx_byte != sbspc_pkg::HDR_BYTE) hdr_err = 1;
          if (pos == 2 && it.rx_byte != addr_id) id_err = 1;
          if (pos == 3) len_byte = it.rx_byte;
          if (pos >= 2) csum = csum + it.rx_byte;
          rx_count   = pos + 8'd1;
          idle_ticks = '0;
          if (rx_count == want_len) begin
            armed = 0;
            owed_replies.push_back(end_packet(1, it.rx_byte, pos, 0));
          end else begin
            r            = '0;
            r.byte_valid = 1'b1;
            r.byte_out   = it.rx_byte;
            r.byte_index = pos;
            owed_replies.push_back(r);
          end
          return 1;
        end
        sbspc_pkg::FUNC_TICK: begin
          if (!armed) return 0;
          idle_ticks = idle_ticks + 1'b1;
          if (idle_ticks > {1'b0, tmo_limit}) begin
            armed = 0;
            owed_replies.push_back(end_packet(0, '0, '0, 1));
          end
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void cmp_field(string name, byte_t want, byte_t got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (owed_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, got %p", $time, got);
        return;
      end
      want = owed_replies.pop_front();
      checked++;
      cmp_field("byte_valid", byte_t'(want.byte_valid), byte_t'(got.byte_valid));
      cmp_field("byte_out", want.byte_out, got.byte_out);
      cmp_field("byte_index", want.byte_index, got.byte_index);
      cmp_field("done_res", byte_t'(want.done_res), byte_t'(got.done_res));
      cmp_field("timed_out", byte_t'(want.timed_out), byte_t'(got.timed_out));
      cmp_field("status", byte_t'(want.status), byte_t'(got.status));
      cmp_field("packet_length", want.packet_length, got.packet_length);
      if (want.done_res) begin
        status_tally[want.status]++;
        if (want.timed_out) timeouts++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [sbspc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sbspc_pkg::CFG_DATA_W-1:0] cfg_data;

  sbspc_in_if  in_ch();
  sbspc_out_if out_ch();

  servo_bus_status_packet_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  packet_scoreboard sb;
  int               counted;       // items the block acts on
  bit               offering;      // mirror of in_ch.valid as last driven
  bit               snd_idle_on;   // sender draws gaps
  bit               rcv_idle_on;   // receiver draws stalls
  bit               rx_hold_req;   // ask the receiver for one long hold-off
  int               quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: give up when no handshake happens on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic servo_item_t mk_item(func_code_t f, byte_t b, byte_t id, byte_t len);
    servo_item_t it;
    it.func         = f;
    it.rx_byte      = b;
    it.expected_id  = id;
    it.expected_len = len;
    return it;
  endfunction

  // Idle tick with random don't-care payload.
  function automatic servo_item_t mk_tick();
    return mk_item(sbspc_pkg::FUNC_TICK, byte_t'($urandom), byte_t'($urandom),
                   byte_t'($urandom));
  endfunction

  // Offer one item after a random gap; hold it until the block takes it.
  task automatic send_item(servo_item_t it);
    int gap;
    gap = snd_idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      if (offering) begin
        in_ch.valid <= 1'b0;
        offering = 0;
      end
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.rx_byte      <= it.rx_byte;
    in_ch.expected_id  <= it.expected_id;
    in_ch.expected_len <= it.expected_len;
    offering = 1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (sb.note_item(it)) counted++;
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 0;
    end
    while (sb.owed_replies.size() != 0) @(posedge clk);
  endtask

  // Bring the block to rest: close an open packet, drain, let the pipe settle.
  task automatic quiesce();
    if (sb.armed) begin
      send_item(mk_item(sbspc_pkg::FUNC_START, byte_t'($urandom), byte_t'($urandom), 8'd0));
    end
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; only call while at rest.
  task automatic write_config(limit_t limit, byte_t bcast);
    cfg_we    <= 1'b1;
    cfg_index <= sbspc_pkg::CFG_TIMEOUT_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    sb.set_reg(sbspc_pkg::CFG_TIMEOUT_LIMIT, limit);
    cfg_index <= sbspc_pkg::CFG_BROADCAST_ID;
    cfg_data  <= {{(sbspc_pkg::CFG_DATA_W-sbspc_pkg::BYTE_W){1'b0}}, bcast};
    @(posedge clk);
    sb.set_reg(sbspc_pkg::CFG_BROADCAST_ID,
               {{(sbspc_pkg::CFG_DATA_W-sbspc_pkg::BYTE_W){1'b0}}, bcast});
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request, check every result.
  task automatic take_results();
    reply_t got;
    int     stall;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rcv_idle_on ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.byte_valid    = out_ch.byte_valid;
      got.byte_out      = out_ch.byte_out;
      got.byte_index    = out_ch.byte_index;
      got.done_res      = out_ch.done_res;
      got.timed_out     = out_ch.timed_out;
      got.status        = sbspc_pkg::status_t'(out_ch.status);
      got.packet_length = out_ch.packet_length;
      sb.check_result(got);
    end
  endtask

  // One reply packet: well formed with random payload or with a single flaw,
  // sometimes cut short and left to time out, or cut short and abandoned.
  task automatic send_reply();
    byte_t body [0:254];
    byte_t id;
    byte_t sum;
    int    n, pick, flaw, ending, cut, k;
    bit    tmo_end;
    pick = $urandom_range(0, 99);
    if (pick < 15) n = $urandom_range(0, 4);
    else if (pick < 75) n = $urandom_range(5, 10);
    else if (pick < 98) n = $urandom_range(11, 40);
    else n = $urandom_range(41, 255);
    id = ($urandom_range(0, 4) == 0) ? sb.bcast_id : byte_t'($urandom_range(0, 255));
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (i < 2) body[i] = sbspc_pkg::HDR_BYTE;
      else if (i == 2) body[i] = id;
      else if (i == 3) body[i] = byte_t'(n - 4);
      else body[i] = byte_t'($urandom_range(0, 255));
      if (i >= 2 && i < n - 1) sum = sum + body[i];
    end
    // make the checksum close the sum, unless the length byte is the last one
    if (n >= 5) body[n-1] = sbspc_pkg::SUM_GOOD - sum;
    flaw = $urandom_range(0, 9);
    case (flaw)
      5: if (n >= 2) body[$urandom_range(0, 1)] ^= byte_t'($urandom_range(1, 255));
      6: if (n >= 3) body[2] ^= byte_t'($urandom_range(1, 255));
      7: if (n >= 4) body[3] ^= byte_t'($urandom_range(1, 255));
      8: if (n >= 5) body[n-1] ^= byte_t'($urandom_range(1, 255));
      9: if (n >= 1) body[$urandom_range(0, n - 1)] = byte_t'($urandom_range(0, 255));
      default: ;
    endcase
    ending  = $urandom_range(0, 9);
    tmo_end = 0;
    cut     = n;
    if (n > 0 && ending >= 7) begin
      cut     = $urandom_range(0, n - 1);
      tmo_end = (ending < 9) && (sb.tmo_limit <= 64);
    end
    send_item(mk_item(sbspc_pkg::FUNC_START, byte_t'($urandom), id, byte_t'(n)));
    for (int i = 0; i < cut; i++) begin
      // sprinkle ticks that stay within the allowed idle time
      if ($urandom_range(0, 3) == 0) begin
        k = (sb.tmo_limit < 3) ? int'(sb.tmo_limit) : 3;
        repeat ($urandom_range(0, k)) send_item(mk_tick());
      end
      send_item(mk_item(sbspc_pkg::FUNC_BYTE, body[i], byte_t'($urandom), byte_t'($urandom)));
    end
    if (tmo_end) begin
      repeat (int'(sb.tmo_limit) + 1) send_item(mk_tick());
    end
  endtask

  // Random part of a phase: reply packets, noise bursts, occasional pauses.
  task automatic random_phase(int quota);
    int first, sel;
    first = counted;
    while (counted - first < quota) begin
      // keep some stretches free of any idling on both sides
      snd_idle_on = ($urandom_range(0, 6) != 0);
      rcv_idle_on = snd_idle_on;
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        send_reply();
      end else if (sel < 97) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(mk_item(func_code_t'($urandom_range(0, 3)), byte_t'($urandom),
                            byte_t'($urandom), byte_t'($urandom)));
        end
      end else begin
        drain();
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps pushing bytes, then pause.
  task automatic flood_while_stalled();
    rx_hold_req = 1;
    snd_idle_on = 0;
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, byte_t'($urandom), 8'd24));
    repeat (24) begin
      send_item(mk_item(sbspc_pkg::FUNC_BYTE, byte_t'($urandom), byte_t'($urandom),
                        byte_t'($urandom)));
    end
    drain();
  endtask

  initial begin
    int unsigned phase_limit [5] = '{3, 12, 1, 0, 7};
    int unsigned phase_bcast [5] = '{0, 255, 90, 165, 254};
    int          fails;

    sb           = new();
    counted      = 0;
    offering     = 0;
    snd_idle_on  = 1;
    rcv_idle_on  = 1;
    rx_hold_req  = 0;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= sbspc_pkg::CFG_TIMEOUT_LIMIT;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= sbspc_pkg::FUNC_START;
    in_ch.rx_byte      <= '0;
    in_ch.expected_id  <= '0;
    in_ch.expected_len <= '0;
    out_ch.ready       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_results();
    join_none

    // Directed part, at the reset register values.
    // Ignored while idle: tick, byte, unused code.
    send_item(mk_item(sbspc_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(2'd3, 8'hFF, 8'hFF, 8'hFF));
    // Zero expected length ends at once.
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, 8'h00, 8'h00));
    // Drop a running packet by restarting, then a minimal good packet.
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, 8'h01, 8'h06));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, 8'hFF, 8'h04));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h00, 8'h00, 8'h00));
    // Byte after the end is ignored.
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h00, 8'hFF, 8'hFF));
    // Broadcast ID: no checks.
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, sbspc_pkg::BROADCAST_RST, 8'h05));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h00, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h11, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h22, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h33, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h44, 8'h00, 8'h00));
    quiesce();
    // Timeout on the first idle tick.
    write_config(16'd0, 8'h33);
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, 8'h10, 8'h08));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00));
    quiesce();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 5; p++) begin
      write_config(limit_t'(phase_limit[p]), byte_t'(phase_bcast[p]));
      if (p == 0) flood_while_stalled();
      random_phase(300);
      quiesce();
    end

    // Largest timeout: a long idle stretch without gaps stays below the limit.
    write_config(16'hFFFF, 8'hFF);
    snd_idle_on = 0;
    send_item(mk_item(sbspc_pkg::FUNC_START, 8'h00, 8'h12, 8'd10));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'hFF, 8'h00, 8'h00));
    send_item(mk_item(sbspc_pkg::FUNC_BYTE, 8'h12, 8'h00, 8'h00));
    repeat (LONG_IDLE) send_item(mk_item(sbspc_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00));
    random_phase(150);
    quiesce();
    repeat (2 * SETTLE) @(posedge clk);

    $display("Covered %0d active items and %0d results; %0d packets timed out.",
             counted, sb.checked, sb.timeouts);
    $display("Verdicts ok/header/id/length/checksum/unchecked: %0d/%0d/%0d/%0d/%0d/%0d",
             sb.status_tally[0], sb.status_tally[1], sb.status_tally[2],
             sb.status_tally[3], sb.status_tally[4], sb.status_tally[5]);
    fails = sb.mismatches + sb.owed_replies.size();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: servo_bus_status_packet_checker.f
hw/rtl/sbspc_pkg.sv
hw/rtl/sbspc_ifs.sv
hw/rtl/sbspc_judge.sv
hw/rtl/servo_bus_status_packet_checker.sv
tb/tb_servo_bus_status_packet_checker.sv
